[src/msm_pkg.sv]
// shared types and constants for the match section merger
`default_nettype none
package msm_pkg;

  localparam int MaxSectionsDef = 64;

  typedef struct packed {
    logic        opcode;
    logic [15:0] pattern_id;
    logic [31:0] match_start;
    logic [31:0] match_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] line_start;
    logic [31:0] line_length;
    logic [31:0] section_start;
    logic [31:0] section_end;
    logic [15:0] section_pattern;
    logic        table_overflow;
    logic        last_section;
  } out_item_t;

  typedef struct packed {
    logic [31:0] sec_start;
    logic [31:0] sec_end;
    logic [15:0] sec_pattern;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_EX,
    ST_INS_DECIDE,
    ST_SHIFT,
    ST_SHIFT_WR,
    ST_CLS_RD,
    ST_CLS_EX,
    ST_CLS_END
  } state_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ITEM_IDX,
    WR_ITEM_POS,
    WR_RD_IDX,
    WR_RD_KEPT
  } wr_op_e;

  typedef struct packed {
    logic   load;
    logic   clear;
    logic   ins_init;
    logic   cls_init;
    logic   idx_inc;
    logic   idx_dec;
    logic   idx_to_count;
    logic   pos_from_idx;
    logic   pos_from_count;
    logic   ovf_set;
    logic   rd_prev;
    wr_op_e wr_op;
    logic   count_inc;
    logic   keep_take;
    logic   emit;
    logic   emit_last;
    logic   close_commit;
  } cmd_t;

  typedef struct packed {
    logic is_blk;
    logic is_end;
    logic idx_eq_count;
    logic idx_eq_pos;
    logic full;
    logic rd_eq;
    logic rd_gt;
    logic better;
    logic keep;
    logic pend_v;
  } status_t;

endpackage
`default_nettype wire

[src/msm_ctrl.sv]
// controller state machine for insert and line-end walk
`default_nettype none
module msm_ctrl import msm_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output logic         busy,
  input  wire status_t sts_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.wr_op = WR_NONE;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (sts_i.is_blk) begin
            cmd_o.clear = 1'b1;
          end else if (sts_i.is_end) begin
            cmd_o.load     = 1'b1;
            cmd_o.cls_init = 1'b1;
            state_d        = ST_CLS_RD;
          end else begin
            cmd_o.load     = 1'b1;
            cmd_o.ins_init = 1'b1;
            state_d        = ST_INS_RD;
          end
        end
      end
      ST_INS_RD: begin
        if (sts_i.idx_eq_count) begin
          cmd_o.pos_from_count = 1'b1;
          state_d              = ST_INS_DECIDE;
        end else begin
          state_d = ST_INS_EX;
        end
      end
      ST_INS_EX: begin
        if (sts_i.rd_eq) begin
          if (sts_i.better) begin
            cmd_o.wr_op = WR_ITEM_IDX;
          end
          state_d = ST_IDLE;
        end else if (sts_i.rd_gt) begin
          cmd_o.pos_from_idx = 1'b1;
          state_d            = ST_INS_DECIDE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_INS_RD;
        end
      end
      ST_INS_DECIDE: begin
        if (sts_i.full) begin
          cmd_o.ovf_set = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.idx_to_count = 1'b1;
          state_d            = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (sts_i.idx_eq_pos) begin
          cmd_o.wr_op     = WR_ITEM_POS;
          cmd_o.count_inc = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        cmd_o.wr_op   = WR_RD_IDX;
        cmd_o.idx_dec = 1'b1;
        state_d       = ST_SHIFT;
      end
      ST_CLS_RD: begin
        state_d = sts_i.idx_eq_count ? ST_CLS_END : ST_CLS_EX;
      end
      ST_CLS_EX: begin
        if (sts_i.keep) begin
          cmd_o.wr_op     = WR_RD_KEPT;
          cmd_o.keep_take = 1'b1;
          cmd_o.emit      = sts_i.pend_v;
        end
        cmd_o.idx_inc = 1'b1;
        state_d       = ST_CLS_RD;
      end
      ST_CLS_END: begin
        cmd_o.emit         = sts_i.pend_v;
        cmd_o.emit_last    = 1'b1;
        cmd_o.close_commit = 1'b1;
        state_d            = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/msm_datapath.sv]
// section table memory, counters and result register
`default_nettype none
module msm_datapath import msm_pkg::*; #(
  parameter int MaxSections = MaxSectionsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire in_item_t    in_i,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire cmd_t        cmd_i,
  output status_t          sts_o,
  output logic             res_valid_o,
  output out_item_t        res_o
);

  localparam int AW = $clog2(MaxSections);
  localparam int CW = $clog2(MaxSections + 1);

  entry_t mem [MaxSections];
  entry_t rd_q;
  entry_t item_q;
  entry_t pend_q;
  entry_t wdata;

  logic [AW-1:0] raddr, waddr;
  logic          we;

  logic [15:0]   cfg_q;
  logic [CW-1:0] count_q, idx_q, pos_q, kept_q;
  logic [31:0]   boundary_q, end_abs_q, reach_q;
  logic          ovf_q, pend_v_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // status towards the controller
  always_comb begin
    sts_o.is_blk       = in_i.opcode;
    sts_o.is_end       = (in_i.pattern_id == cfg_q);
    sts_o.idx_eq_count = (idx_q == count_q);
    sts_o.idx_eq_pos   = (idx_q == pos_q);
    sts_o.full         = (count_q == CW'(MaxSections));
    sts_o.rd_eq        = (rd_q.sec_start == item_q.sec_start);
    sts_o.rd_gt        = (rd_q.sec_start > item_q.sec_start);
    sts_o.better       = (rd_q.sec_end < item_q.sec_end) ||
                         ((rd_q.sec_end == item_q.sec_end) &&
                          (rd_q.sec_pattern > item_q.sec_pattern));
    sts_o.keep         = (kept_q == '0) || (rd_q.sec_start >= reach_q);
    sts_o.pend_v       = pend_v_q;
  end

  // memory address and write select
  always_comb begin
    raddr = cmd_i.rd_prev ? AW'(idx_q - CW'(1)) : idx_q[AW-1:0];
    we    = 1'b1;
    waddr = idx_q[AW-1:0];
    wdata = rd_q;
    case (cmd_i.wr_op)
      WR_ITEM_IDX: wdata = item_q;
      WR_ITEM_POS: begin
        waddr = pos_q[AW-1:0];
        wdata = item_q;
      end
      WR_RD_IDX:   wdata = rd_q;
      WR_RD_KEPT:  waddr = kept_q[AW-1:0];
      default:     we = 1'b0;
    endcase
  end

  // section table, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // current transaction and walk payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q.sec_start   <= in_i.match_start - boundary_q;
      item_q.sec_end     <= in_i.match_end - boundary_q;
      item_q.sec_pattern <= in_i.pattern_id;
      end_abs_q          <= in_i.match_end;
    end
    if (cmd_i.keep_take) begin
      reach_q <= rd_q.sec_end;
      pend_q  <= rd_q;
    end
  end

  // control counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      idx_q      <= '0;
      pos_q      <= '0;
      kept_q     <= '0;
      boundary_q <= '0;
      ovf_q      <= 1'b0;
      pend_v_q   <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q    <= '0;
        boundary_q <= '0;
        ovf_q      <= 1'b0;
      end
      if (cmd_i.ins_init) begin
        idx_q <= '0;
      end
      if (cmd_i.cls_init) begin
        idx_q    <= '0;
        kept_q   <= '0;
        pend_v_q <= 1'b0;
      end
      if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.idx_dec) begin
        idx_q <= idx_q - CW'(1);
      end
      if (cmd_i.idx_to_count) begin
        idx_q <= count_q;
      end
      if (cmd_i.pos_from_idx) begin
        pos_q <= idx_q;
      end
      if (cmd_i.pos_from_count) begin
        pos_q <= count_q;
      end
      if (cmd_i.ovf_set) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.count_inc) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.keep_take) begin
        kept_q   <= kept_q + CW'(1);
        pend_v_q <= 1'b1;
      end
      if (cmd_i.close_commit) begin
        count_q    <= kept_q;
        boundary_q <= end_abs_q;
        ovf_q      <= 1'b0;
      end
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= cmd_i.emit;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_o.line_start      <= boundary_q;
      res_o.line_length     <= end_abs_q - boundary_q;
      res_o.section_start   <= pend_q.sec_start;
      res_o.section_end     <= pend_q.sec_end;
      res_o.section_pattern <= pend_q.sec_pattern;
      res_o.table_overflow  <= ovf_q;
      res_o.last_section    <= cmd_i.emit_last;
    end
  end

endmodule
`default_nettype wire

[src/match_section_merger.sv]
// match section merger: sorted section table with per-line emission
// block begin: handled while idle. insert: scans entries up to the slot, then
//   shifts the later entries up by one to make room.
// line end: walks every table entry; each result strobes for one cycle,
//   the last one in the same cycle that busy falls; the receiver cannot stall results.
// reset clears count, boundary, overflow flag and config; table contents stay undefined.
`default_nettype none
module match_section_merger import msm_pkg::*; #(
  parameter int MaxSections = MaxSectionsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_i,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  output logic             res_valid_o,
  output out_item_t        res_o
);

  cmd_t    cmd;
  status_t sts;

  // controller
  msm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // datapath
  msm_datapath #(
    .MaxSections (MaxSections)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire
